// ===== design/assert_macros.svh =====
// Assertion helpers, clocked on clk_i; ASSERT_CLK is quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check prop at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/scl_pkg.sv =====
package scl_pkg;

  localparam int unsigned LINE_BUFFER_BYTES = 50;
  localparam int unsigned STORE_DEPTH = LINE_BUFFER_BYTES - 1;
  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned MAG_W = 35;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VTAB   = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_Y      = 8'h59;

  localparam logic signed [31:0] F_MAX = 32'sd4095;

  typedef enum logic [2:0] {
    CMD_MANUAL   = 3'd0,
    CMD_FINE_OFF = 3'd1,
    CMD_BRAKE    = 3'd2,
    CMD_POWER    = 3'd3,
    CMD_FINE_ON  = 3'd4,
    CMD_INVERT   = 3'd5,
    CMD_PULSE    = 3'd6,
    CMD_DISABLE  = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PROC,
    S_FIN,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_PRE,
    PH_DIG,
    PH_END
  } ph_e;

  typedef struct packed {
    ph_e              ph;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [31:0]      acc;
  } parse_t;

endpackage

// ===== design/serial_command_line_parser.sv =====
// Serial command line parser.
// Input channel (in_valid_i/in_ready_o, rx_byte_i) takes one received byte per
// request. Carriage returns are ignored; other bytes go into a 49-byte line
// store, and bytes beyond that are dropped. A newline starts a scan of the
// stored line that may yield one request on the output channel
// (out_valid_o/out_ready_i with command_o and the value ports).
// A plain byte is written to the line store when it is taken. A newline
// starts a scan paced by the single read port of the line
// store: each stored byte is read into a register (S_READ) and parsed in
// the state after it (S_PROC). Input is held off for the scan.
// The result sits in an output register, so bytes keep flowing while it waits;
// only the end of the next scan waits for the receiver to take it.
// Reset empties the line store (fill count 0) and drops any pending result.
module serial_command_line_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          command_o,
  output logic signed [31:0]  first_value_o,
  output logic signed [31:0]  second_value_o,
  output logic                pulse_axis_o,
  output logic signed [31:0]  pulse_sign_o,
  output logic [31:0]         pulse_index_o
);
  import scl_pkg::*;

  logic [7:0]    mem_q [STORE_DEPTH];
  logic [7:0]    rdata_q;
  state_e        state_q, state_d;
  logic [CW-1:0] fill_q, n_q, pos_q;
  logic [7:0]    c_q;
  logic          comma_q, infield_q;
  logic [2:0]    fcnt_q;
  parse_t        prs_q;
  logic signed [31:0] v0_q, v1_q;
  logic [31:0]   idx_q;
  logic          axis_ok_q, axis_q;
  logic          out_valid_q;
  logic          accept, take_out, load_out;

  function automatic logic [7:0] upcase(logic [7:0] b);
    return (b >= CH_LA && b <= CH_LZ) ? b - 8'd32 : b;
  endfunction

  function automatic parse_t step(parse_t p, logic [7:0] b);
    parse_t r;
    logic   dig;
    logic [31:0] d;
    r   = p;
    dig = (b >= CH_ZERO) && (b <= CH_NINE);
    d   = {28'd0, b[3:0]};
    unique case (p.ph)
      PH_PRE: begin
        if (b == CH_SPACE || b == CH_TAB || b == CH_VTAB || b == CH_FF) begin
          r.ph = PH_PRE;
        end else if (b == CH_PLUS || b == CH_MINUS) begin
          r.neg = (b == CH_MINUS);
          r.ph  = PH_DIG;
        end else if (dig) begin
          r.acc = d;
          r.mag = MAG_W'(d);
          r.ph  = PH_DIG;
        end else begin
          r.ph = PH_END;
        end
      end
      PH_DIG: begin
        if (dig) begin
          r.acc = (p.acc << 3) + (p.acc << 1) + d;
          if (p.mag <= MAG_W'(64'h8000_0000)) begin
            r.mag = (p.mag << 3) + (p.mag << 1) + MAG_W'(d);
          end
        end else begin
          r.ph = PH_END;
        end
      end
      default: r = p;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat(parse_t p);
    if (p.neg) begin
      return (p.mag >= MAG_W'(64'h8000_0000)) ? 32'sh8000_0000 : -$signed(p.mag[31:0]);
    end
    return (p.mag > MAG_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(p.mag[31:0]);
  endfunction

  function automatic logic signed [31:0] clamp12(logic signed [31:0] v);
    if (v < 0) return 32'sd0;
    if (v > F_MAX) return F_MAX;
    return v;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign take_out    = out_valid_q && out_ready_i;

  // result of the finished scan
  logic               res_vld;
  cmd_e               res_cmd;
  logic signed [31:0] res_a, res_b, res_sign;
  logic [31:0]        res_idx;
  logic               res_axis;

  always_comb begin
    res_vld  = 1'b0;
    res_cmd  = CMD_DISABLE;
    res_a    = '0;
    res_b    = '0;
    res_sign = '0;
    res_idx  = '0;
    res_axis = 1'b0;
    if (pos_q == CW'(1)) begin
      res_vld = 1'b1;
      priority if (c_q == CH_M) res_cmd = CMD_MANUAL;
      else if (c_q == CH_N) res_cmd = CMD_FINE_OFF;
      else if (c_q == CH_B) res_cmd = CMD_BRAKE;
      else res_vld = 1'b0;
    end else if (pos_q > CW'(1) && comma_q) begin
      res_vld = 1'b1;
      priority if (c_q == CH_A) begin
        res_cmd = CMD_POWER;
        res_a   = v0_q;
        res_b   = v1_q;
      end else if (c_q == CH_F) begin
        res_cmd = CMD_FINE_ON;
        res_a   = clamp12(v0_q);
        res_b   = clamp12(v1_q);
      end else if (c_q == CH_I) begin
        res_cmd = CMD_INVERT;
        res_a   = v0_q;
        res_b   = v1_q;
      end else if (c_q == CH_P) begin
        if (fcnt_q >= 3'd3 && axis_ok_q && v1_q != 0) begin
          res_cmd  = CMD_PULSE;
          res_axis = axis_q;
          res_sign = v1_q;
          res_idx  = idx_q;
        end
      end else begin
        res_vld = 1'b0;
      end
    end
  end

  assign load_out = (state_q == S_DONE) && res_vld && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && rx_byte_i == CH_LF) state_d = S_READ;
      S_READ: state_d = (pos_q == n_q) ? S_FIN : S_PROC;
      S_PROC: state_d = (rdata_q == CH_NUL) ? S_FIN : S_READ;
      S_FIN:  state_d = S_DONE;
      S_DONE: if (!res_vld || !out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (take_out) out_valid_q <= 1'b0;
      if (accept && rx_byte_i == CH_LF) begin
        fill_q <= '0;
      end else if (accept && rx_byte_i != CH_CR && fill_q < CW'(STORE_DEPTH)) begin
        fill_q <= fill_q + CW'(1);
      end
    end
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (accept && rx_byte_i != CH_CR && rx_byte_i != CH_LF && fill_q < CW'(STORE_DEPTH)) begin
      mem_q[fill_q[AW-1:0]] <= rx_byte_i;
    end
    if (state_q == S_READ && pos_q != n_q) begin
      rdata_q <= mem_q[pos_q[AW-1:0]];
    end
  end

  // scan datapath
  always_ff @(posedge clk_i) begin
    if (accept && rx_byte_i == CH_LF) begin
      n_q       <= fill_q;
      pos_q     <= '0;
      fcnt_q    <= '0;
      infield_q <= 1'b0;
      comma_q   <= 1'b0;
      v0_q      <= '0;
      v1_q      <= '0;
      idx_q     <= '0;
      axis_ok_q <= 1'b0;
      axis_q    <= 1'b0;
    end
    if (state_q == S_PROC && rdata_q != CH_NUL) begin
      pos_q <= pos_q + CW'(1);
      if (pos_q == CW'(0)) begin
        c_q <= upcase(rdata_q);
      end else if (pos_q == CW'(1)) begin
        comma_q <= (rdata_q == CH_COMMA);
      end else if (rdata_q == CH_COMMA) begin
        // close the open field
        if (infield_q) begin
          infield_q <= 1'b0;
          if (fcnt_q == 3'd1) v0_q <= sat(prs_q);
          if (fcnt_q == 3'd2) v1_q <= sat(prs_q);
          if (fcnt_q == 3'd3) idx_q <= prs_q.neg ? 32'd0 - prs_q.acc : prs_q.acc;
        end
      end else if (!infield_q) begin
        infield_q <= 1'b1;
        if (fcnt_q != 3'd4) fcnt_q <= fcnt_q + 3'd1;
        prs_q <= step('{ph: PH_PRE, neg: 1'b0, mag: '0, acc: '0}, rdata_q);
        if (fcnt_q == 3'd0) begin
          axis_ok_q <= (upcase(rdata_q) == CH_A || rdata_q == CH_ZERO ||
                        upcase(rdata_q) == CH_X || upcase(rdata_q) == CH_B ||
                        rdata_q == CH_ONE || upcase(rdata_q) == CH_Y);
          axis_q    <= (upcase(rdata_q) == CH_B || rdata_q == CH_ONE ||
                        upcase(rdata_q) == CH_Y);
        end
      end else begin
        prs_q <= step(prs_q, rdata_q);
      end
    end
    if (state_q == S_FIN && infield_q) begin
      infield_q <= 1'b0;
      if (fcnt_q == 3'd1) v0_q <= sat(prs_q);
      if (fcnt_q == 3'd2) v1_q <= sat(prs_q);
      if (fcnt_q == 3'd3) idx_q <= prs_q.neg ? 32'd0 - prs_q.acc : prs_q.acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      command_o      <= res_cmd;
      first_value_o  <= res_a;
      second_value_o <= res_b;
      pulse_axis_o   <= res_axis;
      pulse_sign_o   <= res_sign;
      pulse_index_o  <= res_idx;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_fill_bound, fill_q <= CW'(STORE_DEPTH), "fill count beyond store depth")
  `ASSERT_CLK(a_lf_empties, (accept && rx_byte_i == CH_LF) |=> (fill_q == '0), "newline left store filled")
  `ASSERT_CLK(a_scan_bound, (state_q == S_READ || state_q == S_PROC) |-> (pos_q <= n_q), "scan ran past line")
  `ASSERT_CLK(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result raised outside done")

endmodule

// ===== tb/sv/scl_checker.sv =====
module scl_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [2:0]         command_o,
  input  logic signed [31:0] first_value_o,
  input  logic signed [31:0] second_value_o,
  input  logic               pulse_axis_o,
  input  logic signed [31:0] pulse_sign_o,
  input  logic [31:0]        pulse_index_o,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import scl_pkg::*;

  typedef struct {
    cmd_e               cmd;
    logic signed [31:0] val_a;
    logic signed [31:0] val_b;
    logic               axis;
    logic signed [31:0] sign;
    logic [31:0]        index;
  } cmd_rec_t;

  logic [7:0] line_buf [STORE_DEPTH];
  int unsigned line_fill;
  cmd_rec_t cmd_queue[$];

  assign pending_count = cmd_queue.size();

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) ? c - 8'd32 : c;
  endfunction

  // Skip empty fields; report start of the next one and advance past it.
  function automatic bit find_field(int unsigned len, ref int unsigned pos,
                                    output int unsigned start);
    int unsigned p;
    p = pos;
    start = 0;
    while (p < len && line_buf[p] == CH_COMMA) p++;
    if (p >= len) return 0;
    start = p;
    while (p < len && line_buf[p] != CH_COMMA) p++;
    pos = p;
    return 1;
  endfunction

  function automatic void read_decimal(int unsigned p, int unsigned len,
                                       output logic signed [31:0] sat,
                                       output logic [31:0] wrap);
    logic [63:0] mag;
    logic [31:0] acc;
    bit neg;
    mag = 0;
    acc = 0;
    neg = 0;
    while (p < len && (line_buf[p] == CH_SPACE || line_buf[p] == CH_TAB ||
                       line_buf[p] == CH_VTAB || line_buf[p] == CH_FF ||
                       line_buf[p] == CH_LF || line_buf[p] == CH_CR)) p++;
    if (p < len && (line_buf[p] == CH_PLUS || line_buf[p] == CH_MINUS)) begin
      neg = (line_buf[p] == CH_MINUS);
      p++;
    end
    while (p < len && line_buf[p] >= CH_ZERO && line_buf[p] <= CH_NINE) begin
      acc = acc * 10 + 32'(line_buf[p] - CH_ZERO);
      if (mag <= 64'd2147483648) mag = mag * 10 + 64'(line_buf[p] - CH_ZERO);
      p++;
    end
    if (neg) begin
      sat = (mag >= 64'd2147483648) ? 32'sh8000_0000 : -$signed(mag[31:0]);
      wrap = 32'd0 - acc;
    end else begin
      sat = (mag > 64'd2147483647) ? 32'sh7fff_ffff : $signed(mag[31:0]);
      wrap = acc;
    end
  endfunction

  function automatic logic signed [31:0] next_value(int unsigned len,
                                                    ref int unsigned pos);
    int unsigned s;
    logic signed [31:0] v;
    logic [31:0] w;
    v = 0;
    if (find_field(len, pos, s)) read_decimal(s, len, v, w);
    return v;
  endfunction

  function automatic logic signed [31:0] clamp_fine(logic signed [31:0] v);
    if (v < 0) return 0;
    if (v > F_MAX) return F_MAX;
    return v;
  endfunction

  function automatic bit decode_line(int unsigned len, output cmd_rec_t r);
    int unsigned pos, s;
    logic [7:0] c, ax;
    logic signed [31:0] dummy;
    logic [31:0] w;
    r = '{CMD_DISABLE, 0, 0, 0, 0, 0};
    pos = 2;
    if (len == 0) return 0;
    c = to_upper(line_buf[0]);
    if (len == 1) begin
      if (c == CH_M) r.cmd = CMD_MANUAL;
      else if (c == CH_N) r.cmd = CMD_FINE_OFF;
      else if (c == CH_B) r.cmd = CMD_BRAKE;
      else return 0;
      return 1;
    end
    if (line_buf[1] != CH_COMMA) return 0;
    if (c == CH_A || c == CH_F || c == CH_I) begin
      r.val_a = next_value(len, pos);
      r.val_b = next_value(len, pos);
      if (c == CH_A) r.cmd = CMD_POWER;
      else if (c == CH_F) begin
        r.cmd = CMD_FINE_ON;
        r.val_a = clamp_fine(r.val_a);
        r.val_b = clamp_fine(r.val_b);
      end else r.cmd = CMD_INVERT;
      return 1;
    end
    if (c != CH_P) return 0;
    if (find_field(len, pos, s)) begin
      ax = to_upper(line_buf[s]);
      if (ax == CH_B || ax == CH_ONE || ax == CH_Y ||
          ax == CH_A || ax == CH_ZERO || ax == CH_X) begin
        r.axis = (ax == CH_B || ax == CH_ONE || ax == CH_Y);
        if (find_field(len, pos, s)) begin
          read_decimal(s, len, r.sign, w);
          if (r.sign != 0 && find_field(len, pos, s)) begin
            read_decimal(s, len, dummy, r.index);
            r.cmd = CMD_PULSE;
          end
        end
      end
    end
    if (r.cmd == CMD_DISABLE) begin
      r.axis = 0;
      r.sign = 0;
      r.index = 0;
    end
    return 1;
  endfunction

  task automatic take_byte(logic [7:0] b);
    int unsigned len;
    cmd_rec_t r;
    if (b == CH_CR) return;
    if (b == CH_LF) begin
      len = 0;
      while (len < line_fill && line_buf[len] != CH_NUL) len++;
      line_fill = 0;
      if (decode_line(len, r)) cmd_queue.push_back(r);
      return;
    end
    if (line_fill < STORE_DEPTH) begin
      line_buf[line_fill] = b;
      line_fill++;
    end
  endtask

  task automatic compare_cmd();
    cmd_rec_t e;
    if (cmd_queue.size() == 0) begin
      $error("unexpected command request: command %0d", command_o);
      fail_count++;
      return;
    end
    e = cmd_queue.pop_front();
    if (command_o !== e.cmd) begin
      $error("command: expected %0d, got %0d", e.cmd, command_o); fail_count++;
    end
    if (first_value_o !== e.val_a) begin
      $error("first_value: expected %0d, got %0d", e.val_a, first_value_o);
      fail_count++;
    end
    if (second_value_o !== e.val_b) begin
      $error("second_value: expected %0d, got %0d", e.val_b, second_value_o);
      fail_count++;
    end
    if (pulse_axis_o !== e.axis) begin
      $error("pulse_axis: expected %0d, got %0d", e.axis, pulse_axis_o);
      fail_count++;
    end
    if (pulse_sign_o !== e.sign) begin
      $error("pulse_sign: expected %0d, got %0d", e.sign, pulse_sign_o);
      fail_count++;
    end
    if (pulse_index_o !== e.index) begin
      $error("pulse_index: expected %0d, got %0d", e.index, pulse_index_o);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    line_fill = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Outputs first: a request finishing this edge was queued earlier.
      if (out_valid_o && out_ready_i) compare_cmd();
      if (in_valid_i && in_ready_o) take_byte(rx_byte_i);
    end
  end
endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import scl_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [7:0] rx_byte_i = 0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic [2:0] command_o;
  logic signed [31:0] first_value_o, second_value_o, pulse_sign_o;
  logic pulse_axis_o;
  logic [31:0] pulse_index_o;
  int fail_count, pending_count;
  int cycle_count = 0;
  bit calm = 0;
  bit hold_off = 0;
  logic [7:0] line_text[$];

  localparam int CYCLE_LIMIT = 600000;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  serial_command_line_parser uut (.*);

  scl_checker chk (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold so the block backs up.
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 0;
    else if (calm) out_ready_i <= 1;
    else out_ready_i <= ($urandom_range(99) >= 36);
  end

  initial begin
    wait (rst_ni);
    repeat (150) @(posedge clk_i);
    hold_off = 1;
    repeat (1500) @(posedge clk_i);
    hold_off = 0;
  end

  // Hold valid across back-to-back requests; drop it only while idling.
  task automatic send_byte(logic [7:0] b);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CH_LF);
  endtask

  function automatic string rand_number();
    string s;
    int n;
    case ($urandom_range(5))
      0: s = "";
      1: s = "-";
      2: s = "+";
      3: s = " ";
      default: s = "";
    endcase
    n = $urandom_range(1, ($urandom_range(3) == 0) ? 12 : 4);
    for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(9)))};
    if ($urandom_range(9) == 0) s = {s, "x"};
    return s;
  endfunction

  function automatic string rand_line();
    string s, h;
    int k;
    k = $urandom_range(19);
    if (k < 2) begin
      h = "MNBmnb";
      return string'(h[$urandom_range(5)]);
    end
    if (k < 16) begin
      h = "AFIPafip";
      s = {string'(h[$urandom_range(7)]), ","};
      if (s[0] == "P" || s[0] == "p") begin
        h = "AaBbXxYy01QZ";
        s = {s, string'(h[$urandom_range(($urandom_range(4) == 0) ? 11 : 9)])};
        if ($urandom_range(5) == 0) s = {s, ","};
        s = {s, ",", ($urandom_range(7) == 0) ? "0" : rand_number()};
        if ($urandom_range(7) != 0) s = {s, ",", rand_number()};
      end else begin
        s = {s, rand_number()};
        if ($urandom_range(5) == 0) s = {s, ",,"};
        if ($urandom_range(5) != 0) s = {s, ",", rand_number()};
      end
      return s;
    end
    // Noise: random bytes, occasionally long enough to overflow the store.
    s = "";
    k = ($urandom_range(3) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 6);
    for (int i = 0; i < k; i++) begin
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == CH_LF) b = CH_CR;
      s = {s, string'(b == 0 ? 8'h01 : b)};
    end
    return s;
  endfunction

  int sent;

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_line("M"); send_line("n"); send_line("B"); send_line("Q");
    send_line("A,2147483647,-2147483648");
    send_line("a,99999999999,-99999999999");
    send_line("F,-5,5000"); send_line("f,4095,0");
    send_line("I,,,7"); send_line("I,"); send_line("");
    send_line("P,X,-3,4294967295"); send_line("p,y,+1,-1");
    send_line("P,2,1,1"); send_line("P,a,0,5"); send_line("P,b,4");
    send_line("P"); send_line("A\r,1\r,2");
    send_line("MM"); send_line("AX,1");
    // Zero byte ends the line early.
    send_byte("A"); send_byte(","); send_byte("5"); send_byte(CH_NUL);
    send_byte("9"); send_byte(CH_LF);
    send_byte(CH_NUL); send_byte(CH_LF);
    // Overflow the store; the bytes beyond it are dropped.
    send_line("A,\t1,00000000000000000000000000000000000000000000000000077");
    send_byte(8'hFF); send_byte(8'hFF); send_byte(CH_LF);
    sent = 0;
    while (sent < 470) begin
      string s;
      calm = (sent >= 200 && sent < 280);
      s = rand_line();
      send_line(s);
      sent += s.len() + 1;
    end
    in_valid_i <= 0;
    calm = 0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
